@@ rtl/core/eemi_pkg.sv @@
// Shared types for the extended Euclid modular inverse core.
package eemi_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_SWAP,
    ST_NORM_WRAP,
    ST_NORM_SIGN,
    ST_DONE
  } eemi_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_start;  // take a new word, start the reduction a mod m
    logic align_step;  // shift divisor and coefficient left one place
    logic sub_step;    // conditional subtract, then shift right one place
    logic swap_init;   // end of reduction: set up r/s pairs
    logic swap_iter;   // end of a Euclid step: rotate r/s pairs and signs
    logic norm_wrap;   // bring s0 below m
    logic norm_sign;   // turn a negative coefficient into its residue
    logic load_out;    // copy the result into the output register
  } eemi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_zero;    // configured modulus is zero
    logic align_more;  // another left shift still keeps divisor <= dividend
    logic count_zero;  // last subtract position reached
    logic rem_zero;    // remainder just produced is zero
  } eemi_status_t;

endpackage

@@ rtl/core/eemi_ctrl.sv @@
// Sequencer for the extended Euclid core: divisions, swaps, final normalization.
module eemi_ctrl
  import eemi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  eemi_status_t st,
  output eemi_cmd_t    cmd
);

  eemi_state_t state, state_next;
  logic        reducing, reducing_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      reducing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      reducing  <= reducing_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    reducing_next  = reducing;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_start = 1'b1;
          reducing_next  = 1'b1;
          state_next     = st.mod_zero ? ST_DONE : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (st.align_more) begin
          cmd.align_step = 1'b1;
        end else begin
          state_next = ST_SUB;
        end
      end
      ST_SUB: begin
        cmd.sub_step = 1'b1;
        if (st.count_zero) begin
          state_next = ST_SWAP;
        end
      end
      ST_SWAP: begin
        if (reducing) begin
          cmd.swap_init = 1'b1;
        end else begin
          cmd.swap_iter = 1'b1;
        end
        reducing_next = 1'b0;
        state_next    = st.rem_zero ? ST_NORM_WRAP : ST_ALIGN;
      end
      ST_NORM_WRAP: begin
        cmd.norm_wrap = 1'b1;
        state_next    = ST_NORM_SIGN;
      end
      ST_NORM_SIGN: begin
        cmd.norm_sign = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/eemi_dp.sv @@
// Datapath: modulus register, remainder/coefficient pairs, shift-subtract divider.
module eemi_dp
  import eemi_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  eemi_cmd_t        cmd,
  output eemi_status_t     st,
  input  logic [WIDTH-1:0] value,
  input  logic             cfg_we,
  input  logic [WIDTH-1:0] cfg_data,
  output logic [WIDTH-1:0] inverse,
  output logic [WIDTH-1:0] divisor,
  output logic             exists
);

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] r0, r1, s0, s1;  // remainders and coefficient magnitudes
  logic             n0, n1;          // coefficient signs, 1 = negative
  logic [WIDTH-1:0] d, sd;           // shifted divisor and shifted coefficient
  logic [KW-1:0]    k;               // current shift amount
  logic             mz;              // item taken with modulus zero

  logic             ge;
  logic             done_one;

  assign ge       = (r0 >= d);
  assign done_one = (r0 == {{(WIDTH-1){1'b0}}, 1'b1}) & ~mz;

  assign st.mod_zero   = (modulus == '0);
  assign st.align_more = ~d[WIDTH-1] & ({d, 1'b0} <= {1'b0, r0});
  assign st.count_zero = (k == '0);
  assign st.rem_zero   = (r0 == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(191);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      // first pass reduces a mod m with no coefficient tracking
      r0 <= value;
      r1 <= modulus;
      s0 <= '0;
      s1 <= '0;
      d  <= modulus;
      sd <= '0;
      k  <= '0;
      mz <= (modulus == '0);
    end
    if (cmd.align_step) begin
      d  <= {d[WIDTH-2:0], 1'b0};
      sd <= {sd[WIDTH-2:0], 1'b0};
      k  <= k + KW'(1);
    end
    if (cmd.sub_step) begin
      if (ge) begin
        r0 <= r0 - d;
        s0 <= s0 + sd;
      end
      d  <= {1'b0, d[WIDTH-1:1]};
      sd <= {1'b0, sd[WIDTH-1:1]};
      if (k != '0) begin
        k <= k - KW'(1);
      end
    end
    if (cmd.swap_init) begin
      r0 <= r1;
      r1 <= r0;
      s0 <= '0;
      s1 <= {{(WIDTH-1){1'b0}}, 1'b1};
      n0 <= 1'b0;
      n1 <= 1'b0;
      d  <= r0;
      sd <= {{(WIDTH-1){1'b0}}, 1'b1};
      k  <= '0;
    end
    if (cmd.swap_iter) begin
      r0 <= r1;
      r1 <= r0;
      s0 <= s1;
      s1 <= s0;
      n0 <= n1;
      n1 <= ~n1;
      d  <= r0;
      sd <= s0;
      k  <= '0;
    end
    if (cmd.norm_wrap) begin
      if (s0 >= modulus) begin
        s0 <= s0 - modulus;
      end
    end
    if (cmd.norm_sign) begin
      if (n0 && (s0 != '0)) begin
        s0 <= modulus - s0;
      end
    end
    if (cmd.load_out) begin
      divisor <= r0;
      exists  <= done_one;
      inverse <= done_one ? s0 : '0;
    end
  end

endmodule

@@ rtl/core/extended_euclid_modular_inverse_core.sv @@
// Top level of the extended Euclid modular inverse core.
//
// Usage: each word on the s_axis channel carries a value a. The core returns
// one word on the m_axis channel with gcd(a, m), a flag set when the gcd is
// one, and a^-1 mod m in 0..m-1 (zero when no inverse exists). The modulus m
// is written through cfg_valid/cfg_data; cfg_ready is always high. Write it
// only while the core is idle.
// Flow: one word is computed at a time. Each Euclid step is a division: the
// divisor is shifted left while it stays at or below the dividend, then one
// conditional subtract and right shift runs per quotient bit, then a swap.
// After the last step come two normalize steps (wrap, sign) and the output
// load. A modulus of zero skips straight from the start to the output load.
// Reset: the modulus returns to 191, the sequencer goes idle, no word is
// pending on the output.
// Stall: the result sits in an output register; a new input word is taken
// while it waits, and the finished next result holds until the first leaves.
module extended_euclid_modular_inverse_core
  import eemi_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: value
  input  logic [((WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: inverse, divisor
  output logic [((2*WIDTH+7)/8)*8-1:0]    m_axis_tdata,
  // tuser: exists
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [WIDTH-1:0]                cfg_data
);

  localparam int OUT_TW = ((2*WIDTH+7)/8)*8;

  eemi_cmd_t        cmd;
  eemi_status_t     st;
  logic [WIDTH-1:0] inverse, divisor;
  logic             exists;

  assign cfg_ready = 1'b1;

  eemi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  eemi_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .value    (s_axis_tdata[WIDTH-1:0]),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .inverse  (inverse),
    .divisor  (divisor),
    .exists   (exists)
  );

  // pack result fields, low field first, zero fill to whole bytes
  assign m_axis_tdata = OUT_TW'({divisor, inverse});
  assign m_axis_tuser = exists;

endmodule

@@ sim/eemi_inverse_monitor.sv @@
`timescale 1ns / 1ps
// Channel monitor for the modular inverse core: predicts each result word and compares it.
module eemi_inverse_monitor #(
  parameter int WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // tdata: value
  input  logic [((WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // tdata: inverse, divisor
  input  logic [((2*WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  // tuser: exists
  input  logic [0:0]                    m_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [WIDTH-1:0]              cfg_data,
  output int                            mismatches,
  output int                            outstanding
);

  localparam logic [WIDTH-1:0] RESET_MODULUS = 191;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] inverse;
    logic [WIDTH-1:0] divisor;
    logic             exists;
  } inverse_due_t;

  inverse_due_t     inverse_due_q[$];
  logic [WIDTH-1:0] modulus_shadow;
  int               errs = 0;

  // Extended Euclid with coefficient magnitudes and an alternating sign.
  function automatic inverse_due_t predict_inverse(input logic [WIDTH-1:0] a,
                                                   input logic [WIDTH-1:0] m);
    inverse_due_t res;
    logic [63:0]  r_prev, r_cur, r_next, quo, s_prev, s_cur, s_next;
    logic         neg_prev, neg_cur;
    res = '0;
    res.value = a;
    res.modulus = m;
    if (m == '0) begin
      res.divisor = a;
      return res;
    end
    r_prev = 64'(m);
    r_cur = 64'(a) % 64'(m);
    s_prev = 64'd0;
    s_cur = 64'd1;
    neg_prev = 1'b0;
    neg_cur = 1'b0;
    while (r_cur != 64'd0) begin
      quo = r_prev / r_cur;
      r_next = r_prev - quo * r_cur;
      s_next = s_prev + quo * s_cur;
      r_prev = r_cur;
      r_cur = r_next;
      s_prev = s_cur;
      neg_prev = neg_cur;
      s_cur = s_next;
      neg_cur = !neg_cur;
    end
    res.divisor = r_prev[WIDTH-1:0];
    res.exists = (r_prev == 64'd1);
    if (res.exists) begin
      s_prev = s_prev % 64'(m);
      if (neg_prev && s_prev != 64'd0) begin
        s_prev = 64'(m) - s_prev;
      end
      res.inverse = s_prev[WIDTH-1:0];
    end
    return res;
  endfunction

  task automatic report(input string field, input inverse_due_t want,
                        input logic [WIDTH-1:0] exp_v, input logic [WIDTH-1:0] got_v);
    errs++;
    $display("%0t: %s wrong for value %h mod %h: expected %h, actual %h",
             $time, field, want.value, want.modulus, exp_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    inverse_due_t want;
    if (rst) begin
      modulus_shadow = RESET_MODULUS;
      inverse_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        modulus_shadow = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        inverse_due_q.push_back(predict_inverse(s_axis_tdata[WIDTH-1:0], modulus_shadow));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_due_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word: expected none, actual %h / %h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = inverse_due_q.pop_front();
          if (m_axis_tdata[WIDTH-1:0] !== want.inverse) begin
            report("inverse", want, want.inverse, m_axis_tdata[WIDTH-1:0]);
          end
          if (m_axis_tdata[2*WIDTH-1:WIDTH] !== want.divisor) begin
            report("divisor", want, want.divisor, m_axis_tdata[2*WIDTH-1:WIDTH]);
          end
          if (m_axis_tuser[0] !== want.exists) begin
            report("exists", want, WIDTH'(want.exists), WIDTH'(m_axis_tuser[0]));
          end
        end
      end
    end
    mismatches <= errs;
    outstanding <= inverse_due_q.size();
  end

endmodule

@@ sim/extended_euclid_modular_inverse_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the modular inverse core: clock, reset, stimulus and verdict.
module extended_euclid_modular_inverse_core_tb;

  localparam int WIDTH = 32;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 86;
  localparam int QUIET_LIMIT = 5000;   // must exceed the slowest word plus stalls
  localparam int TAIL_CYCLES = 400;
  localparam logic [WIDTH-1:0] FIB_47 = 32'd2971215073;
  localparam logic [WIDTH-1:0] FIB_46 = 32'd1836311903;
  localparam logic [WIDTH-1:0] PRIME_TOP = 32'd4294967291;

  logic                          clk;
  logic                          rst;
  logic [((WIDTH+7)/8)*8-1:0]    s_axis_tdata;    // value
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [((2*WIDTH+7)/8)*8-1:0]  m_axis_tdata;    // inverse, divisor
  logic [0:0]                    m_axis_tuser;    // exists
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [WIDTH-1:0]              cfg_data;

  bit idle_enable;
  int mismatches;
  int outstanding;
  int quiet_cycles = 0;

  extended_euclid_modular_inverse_core #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  eemi_inverse_monitor #(
    .WIDTH(WIDTH)
  ) i_monitor (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin : result_ready
    int hold;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[extended_euclid_modular_inverse_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one value word; valid stays high into the next word unless a gap is taken.
  task automatic send_value(input logic [WIDTH-1:0] v);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= v;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and wait for every predicted result word to come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Modulus changes only with the core idle.
  task automatic retune_modulus(input logic [WIDTH-1:0] m);
    settle();
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [WIDTH-1:0] mod_now;
    logic [WIDTH-1:0] val;
    rst <= 1'b1;
    s_axis_tdata <= '0;
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    idle_enable = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset modulus 191: zero, one, around and at the modulus, a multiple, all ones.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd190);
    send_value(32'd191);
    send_value(32'd192);
    send_value(32'd382);
    send_value(32'hFFFF_FFFF);

    // Largest modulus, composite: common factor and reduction of equal value.
    retune_modulus(32'hFFFF_FFFF);
    send_value(32'd1);
    send_value(32'd3);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFE);
    send_value(32'hFFFF_FFFF);

    // Smallest legal modulus.
    retune_modulus(32'd2);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);

    // Modulus zero: divisor passes the value through.
    retune_modulus(32'd0);
    send_value(32'd0);
    send_value(32'd5);
    send_value(32'hFFFF_FFFF);

    // Modulus one: everything is its own inverse class, inverse 0.
    retune_modulus(32'd1);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);

    // Consecutive Fibonacci numbers: longest Euclid chain in 32 bits.
    retune_modulus(FIB_47);
    send_value(FIB_46);
    send_value(FIB_47 - 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: mod_now = $urandom_range(2, 1000);
        1: mod_now = $urandom;
        2: mod_now = PRIME_TOP;
        3: mod_now = $urandom & ~32'hF;
        4: mod_now = 32'h1 << $urandom_range(1, 31);
        default: mod_now = $urandom_range(2, 65536) * $urandom_range(1, 3);
      endcase
      if (mod_now < 2) begin
        mod_now = 32'd2;
      end
      retune_modulus(mod_now);
      // Final phase runs with both sides at full rate.
      idle_enable = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: val = $urandom;
          4: val = $urandom_range(0, 1000);
          5: val = $urandom % mod_now;
          6: val = mod_now * $urandom_range(0, 5);
          7: val = $urandom & ~32'h7;
          8: val = mod_now + $urandom_range(0, 1000);
          default: val = 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
        send_value(val);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[extended_euclid_modular_inverse_core] OK");
    end else begin
      $display("[extended_euclid_modular_inverse_core] ERROR");
    end
    $finish;
  end

endmodule
